// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the wind vane circular mean RTL.
// Depends on nothing; each macro is empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WVCM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wvcm assertion failed");
`define WVCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wvcm assertion failed");
`else
`define WVCM_ASSERT_NOW(label, clk, rst, ante, cons)
`define WVCM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/wvcm_pkg.sv =====
// Shared types, constants and the arctangent table of the wind vane circular mean.
// Used by the CORDIC cell, the cell chain and the top level.
package wvcm_pkg;

  localparam int ANGLE_BITS_DEF         = 16;
  localparam int TRIG_FRACTION_BITS_DEF = 15;
  localparam int CORDIC_STEPS_DEF       = 16;

  localparam int XY_W  = 48;
  localparam int Z_W   = 34;
  localparam int SUM_W = 22;

  localparam logic [1:0] REG_NORTH_OFFSET = 2'd0;
  localparam logic [1:0] REG_REVERSE      = 2'd1;
  localparam logic [1:0] REG_BURST_LENGTH = 2'd2;
  localparam logic [1:0] REG_MIN_VALID    = 2'd3;

  typedef struct packed {
    logic                   valid;
    logic                   vec;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic        [Z_W-1:0]  z;
  } cell_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/wvcm_cell.sv =====
// One CORDIC micro-rotation cell with a fixed shift, for rotation or vectoring.
// Depends on wvcm_pkg.
module wvcm_cell #(
  parameter int SHIFT = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  wvcm_pkg::cell_t din,
  output wvcm_pkg::cell_t dout
);
  import wvcm_pkg::*;

  localparam logic [Z_W-1:0] ATAN = Z_W'(atan_turn(SHIFT));

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic                   up;

  assign dx = din.y >>> SHIFT;
  assign dy = din.x >>> SHIFT;
  // Rotation drives z toward zero, vectoring drives y toward zero.
  assign up = din.vec ? !(din.y > 0) : !din.z[Z_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.vec <= din.vec;
    if (up) begin
      dout.x <= din.x - dx;
      dout.y <= din.y + dy;
      dout.z <= din.z - ATAN;
    end else begin
      dout.x <= din.x + dx;
      dout.y <= din.y - dy;
      dout.z <= din.z + ATAN;
    end
  end

endmodule

// ===== hdl/wvcm_chain.sv =====
// Row of CORDIC cells; each cell hands its vector and angle to the next every cycle.
// Depends on wvcm_pkg and wvcm_cell.
module wvcm_chain #(
  parameter int CORDIC_STEPS = wvcm_pkg::CORDIC_STEPS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  wvcm_pkg::cell_t din,
  output wvcm_pkg::cell_t dout
);
  import wvcm_pkg::*;

  cell_t link [CORDIC_STEPS+1];

  assign link[0] = din;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    wvcm_cell #(.SHIFT(i)) u_cell (
      .clk (clk),
      .rst (rst),
      .din (link[i]),
      .dout(link[i+1])
    );
  end

  assign dout = link[CORDIC_STEPS];

endmodule

// ===== hdl/wind_vane_circular_mean_core.sv =====
// Wind vane circular mean: CORDIC unit vectors summed over a burst, atan2 at the end.
// A good sample is rotated through the cell chain and then summed; a discarded one
// is only counted. A burst end vectors the sums through the chain before the result
// word is presented. One sample word is in flight at a time.
// Synchronous active-high reset clears sums, counters, handshakes and the configuration registers.
module wind_vane_circular_mean_core #(
  parameter int ANGLE_BITS         = wvcm_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRACTION_BITS = wvcm_pkg::TRIG_FRACTION_BITS_DEF,
  parameter int CORDIC_STEPS       = wvcm_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] raw_angle,
  input  logic        read_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] direction,
  output logic        result_ok,
  output logic [5:0]  good_samples
);
  import wvcm_pkg::*;

  `include "assert_macros.svh"

  // Controller states. IDLE is the only state that takes a sample word.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ROT    = 3'd1;
  localparam logic [2:0] S_VSTART = 3'd2;
  localparam logic [2:0] S_VEC    = 3'd3;
  localparam logic [2:0] S_HOLD   = 3'd4;

  // Rounded CORDIC gain compensation as the starting x of a rotation.
  localparam longint GAIN_L = ((64'd2608131496 << TRIG_FRACTION_BITS) + 64'h80000000) >> 32;
  localparam logic signed [XY_W-1:0] GAIN_X = XY_W'(GAIN_L);
  localparam logic signed [XY_W-1:0] LIM    = XY_W'((longint'(1) << TRIG_FRACTION_BITS) - 1);
  localparam logic signed [SUM_W:0]  SUM_MAX = (SUM_W+1)'((longint'(1) << (SUM_W-1)) - 1);
  localparam logic signed [SUM_W:0]  SUM_MIN = -(SUM_W+1)'(longint'(1) << (SUM_W-1));

  // Configuration registers.
  logic [15:0] north_offset;
  logic        reverse_direction;
  logic [5:0]  burst_length;
  logic [5:0]  min_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      north_offset      <= '0;
      reverse_direction <= 1'b0;
      burst_length      <= 6'd30;
      min_valid         <= 6'd15;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NORTH_OFFSET: north_offset      <= cfg_data;
        REG_REVERSE:      reverse_direction <= cfg_data[0];
        REG_BURST_LENGTH: burst_length      <= cfg_data[5:0];
        REG_MIN_VALID:    min_valid         <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  logic [2:0] state;
  logic       in_accept;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Angle preparation: scale to ANGLE_BITS, mirror, subtract north, fold into the
  // quarter turn around the nearest axis so the CORDIC only sees +-1/8 turn.
  logic [ANGLE_BITS-1:0] ang_raw;
  logic [ANGLE_BITS-1:0] ang_mir;
  logic [ANGLE_BITS-1:0] ang_cal;
  logic [ANGLE_BITS-1:0] ang_off;
  logic [39:0]           off_wide;
  logic [31:0]           turn;
  logic [31:0]           turn_bias;
  logic [1:0]            quad;
  logic [31:0]           turn_rem;

  assign ang_raw   = ANGLE_BITS'(raw_angle) << (ANGLE_BITS - 12);
  assign off_wide  = 40'(north_offset) << ANGLE_BITS;
  assign ang_off   = off_wide[ANGLE_BITS+15:16];
  assign ang_mir   = reverse_direction ? (ANGLE_BITS'(0) - ang_raw) : ang_raw;
  assign ang_cal   = ang_mir - ang_off;
  assign turn      = 32'(ang_cal) << (32 - ANGLE_BITS);
  assign turn_bias = turn + 32'h20000000;
  assign quad      = turn_bias[31:30];
  assign turn_rem  = turn - {quad, 30'b0};

  // Burst counters and running sums.
  logic [5:0]              items_seen;
  logic [5:0]              good_count;
  logic [5:0]              items_next;
  logic                    burst_end;
  logic                    end_pending;
  logic [1:0]              quad_q;
  logic signed [SUM_W-1:0] sum_cos;
  logic signed [SUM_W-1:0] sum_sin;

  assign items_next = items_seen + 6'd1;

  // The chain is shared: a good sample rotates, a burst end vectors the sums.
  cell_t chain_in;
  cell_t chain_out;
  logic  launch_rot;
  logic  launch_vec;

  assign launch_rot = in_accept && read_ok;
  assign launch_vec = (state == S_VSTART);

  always_comb begin
    chain_in       = '0;
    chain_in.valid = launch_rot || launch_vec;
    if (launch_vec) begin
      chain_in.vec = 1'b1;
      // Vectoring starts with the sums scaled up by 2^24, mirrored into the
      // right half plane with a half turn added when x is negative.
      if (sum_cos < 0) begin
        chain_in.x = -(XY_W'(sum_cos) <<< 24);
        chain_in.y = -(XY_W'(sum_sin) <<< 24);
        chain_in.z = Z_W'(32'h80000000);
      end else begin
        chain_in.x = XY_W'(sum_cos) <<< 24;
        chain_in.y = XY_W'(sum_sin) <<< 24;
      end
    end else begin
      chain_in.vec = 1'b0;
      chain_in.x   = GAIN_X;
      chain_in.z   = Z_W'(signed'(turn_rem));
    end
  end

  wvcm_chain #(.CORDIC_STEPS(CORDIC_STEPS)) u_chain (
    .clk (clk),
    .rst (rst),
    .din (chain_in),
    .dout(chain_out)
  );

  // Clamp the rotated vector, turn it back into its quadrant and accumulate
  // with saturation at the limits of the sum registers.
  logic signed [XY_W-1:0]  cx;
  logic signed [XY_W-1:0]  cy;
  logic signed [XY_W-1:0]  vc;
  logic signed [XY_W-1:0]  vs;
  logic signed [SUM_W:0]   acc_c;
  logic signed [SUM_W:0]   acc_s;
  logic signed [SUM_W-1:0] sat_c;
  logic signed [SUM_W-1:0] sat_s;

  always_comb begin
    cx = (chain_out.x > LIM) ? LIM : ((chain_out.x < -LIM) ? -LIM : chain_out.x);
    cy = (chain_out.y > LIM) ? LIM : ((chain_out.y < -LIM) ? -LIM : chain_out.y);
    case (quad_q)
      2'd0:    begin vc = cx;  vs = cy;  end
      2'd1:    begin vc = -cy; vs = cx;  end
      2'd2:    begin vc = -cx; vs = -cy; end
      default: begin vc = cy;  vs = -cx; end
    endcase
    acc_c = (SUM_W+1)'(sum_cos) + (SUM_W+1)'(vc);
    acc_s = (SUM_W+1)'(sum_sin) + (SUM_W+1)'(vs);
    sat_c = (acc_c > SUM_MAX) ? SUM_W'(SUM_MAX) :
            ((acc_c < SUM_MIN) ? SUM_W'(SUM_MIN) : SUM_W'(acc_c));
    sat_s = (acc_s > SUM_MAX) ? SUM_W'(SUM_MAX) :
            ((acc_s < SUM_MIN) ? SUM_W'(SUM_MIN) : SUM_W'(acc_s));
  end

  // Result held from the burst end until the output register is free.
  logic        res_ok;
  logic        res_zero;
  logic [5:0]  res_count;
  logic [15:0] res_dir;
  logic [31:0] z_round;
  logic        out_free;

  assign z_round  = chain_out.z[31:0] + 32'h8000;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      items_seen  <= '0;
      good_count  <= '0;
      sum_cos     <= '0;
      sum_sin     <= '0;
      end_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // In HOLD the output register is reloaded instead of emptied.
      if (out_valid && !out_stall && (state != S_HOLD)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            items_seen  <= items_next;
            good_count  <= good_count + 6'(read_ok);
            end_pending <= burst_end;
            quad_q      <= quad;
            if (read_ok) begin
              state <= S_ROT;
            end else if (burst_end) begin
              state <= S_VSTART;
            end
          end
        end
        S_ROT: begin
          if (chain_out.valid) begin
            sum_cos <= sat_c;
            sum_sin <= sat_s;
            state   <= end_pending ? S_VSTART : S_IDLE;
          end
        end
        S_VSTART: begin
          res_ok     <= (good_count >= min_valid);
          res_count  <= good_count;
          res_zero   <= (sum_cos == '0) && (sum_sin == '0);
          sum_cos    <= '0;
          sum_sin    <= '0;
          items_seen <= '0;
          good_count <= '0;
          state      <= S_VEC;
        end
        S_VEC: begin
          if (chain_out.valid) begin
            res_dir <= z_round[31:16];
            state   <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            direction    <= (res_ok && !res_zero) ? res_dir : 16'd0;
            result_ok    <= res_ok;
            good_samples <= res_count;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign burst_end = !(items_next < burst_length);

  `WVCM_ASSERT_NOW(a_chain_busy, clk, rst, chain_out.valid, (state == S_ROT) || (state == S_VEC))
  `WVCM_ASSERT_NEXT(a_burst_clear, clk, rst, state == S_VSTART, (items_seen == 6'd0) && (good_count == 6'd0))
  `WVCM_ASSERT_NOW(a_err_zero, clk, rst, out_valid && !result_ok, direction == 16'd0)

endmodule
